### rtl/core/nsc_pkg.sv
// Package for the NMEA sentence checksum checker.
// Holds the phase and status codes, the result struct and the digit decoder.
// No dependencies.
`timescale 1ns / 1ps

package nsc_pkg;

	// Character constants of the sentence format.
	localparam logic [7:0] STAR_CHAR  = 8'h2A;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] NINE_CHAR  = 8'h39;
	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_Z    = 8'h5A;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_Z    = 8'h7A;
	localparam logic [7:0] LETTER_OFS = 8'd10;

	// Minimum number of bytes before the first star, saturation limits.
	localparam logic [2:0] MIN_BODY      = 3'd5;
	localparam logic [1:0] DIGITS_NEEDED = 2'd2;
	localparam logic [1:0] DIGIT_SAT     = 2'd3;

	// Verdict codes.
	localparam logic [2:0] ST_MATCH    = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_NO_CSUM  = 3'd2;
	localparam logic [2:0] ST_BAD_LEN  = 3'd3;
	localparam logic [2:0] ST_BAD_DIG  = 3'd4;
	localparam logic [2:0] ST_MISMATCH = 3'd5;

	// Parse phase, one-hot.
	typedef enum logic [2:0] {
		PH_BODY = 3'b001,
		PH_SUM  = 3'b010,
		PH_TAIL = 3'b100
	} phase_t;

	// One verdict item.
	typedef struct packed {
		logic [7:0] computed_sum;
		logic [2:0] status;
		logic       checksum_ok;
	} result_t;

	// Decoded checksum character.
	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} digit_t;

	// Map a character to its digit value; letters give 10 and up.
	function automatic digit_t char_value(input logic [7:0] c);
		digit_t     d;
		logic [7:0] diff;
		d    = '0;
		diff = 8'd0;
		if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
			diff = c - ZERO_CHAR;
			d.ok = 1'b1;
		end else if (c >= UPPER_A && c <= UPPER_Z) begin
			diff = c - UPPER_A + LETTER_OFS;
			d.ok = 1'b1;
		end else if (c >= LOWER_A && c <= LOWER_Z) begin
			diff = c - LOWER_A + LETTER_OFS;
			d.ok = 1'b1;
		end
		d.val = diff[5:0];
		return d;
	endfunction

endpackage

### rtl/core/nmea_sentence_checksum_check.sv
// NMEA sentence checksum checker, one byte per item, one verdict per sentence.
// Throughput: one byte per cycle; a last byte waits in the input register while
// the result register still holds an earlier verdict that the sink has not taken.
// The last byte of a sentence passes the input register, then its verdict is
// captured in the result register, from which it leaves when the sink takes it.
// Reset: arst_n clears the parse state and both valid flags asynchronously.
`timescale 1ns / 1ps

module nmea_sentence_checksum_check import nsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] msg_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] checksum_ok, [3:1] status, [11:4] computed_sum, rest 0
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       step;
	logic       space;
	result_t    res;
	result_t    out_data;

	// A byte in the input register moves on unless it is a last byte
	// facing a full output register.
	assign step     = valid_s1 && (!last_s1 || space);
	assign s_tready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	nsc_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.msg_byte (byte_s1),
		.last     (last_s1),
		.res      (res)
	);

	nsc_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && last_s1),
		.res    (res),
		.space  (space),
		.tvalid (m_tvalid),
		.tready (m_tready),
		.data   (out_data)
	);

	assign m_tdata = {4'b0000, out_data};

	// The pass flag agrees with the status code.
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_data.checksum_ok ==
			(out_data.status == ST_MATCH || out_data.status == ST_NO_CSUM)))
		else $error("checksum_ok disagrees with status");

	// A sentence end always produces a verdict on the next cycle.
	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> m_tvalid && out_data == $past(res))
		else $error("verdict not captured");

	// A too-short verdict is never a pass.
	a_short_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_data.status == ST_SHORT |-> !out_data.checksum_ok)
		else $error("short sentence passed");

	// The status code never leaves its defined range.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_data.status <= ST_MISMATCH)
		else $error("status out of range");

endmodule

### rtl/core/nsc_parse.sv
// Sentence parser: phase, counters, running XOR and received checksum.
// Forms the verdict for the last byte combinationally. Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_parse import nsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] msg_byte,
	input  logic       last,
	output result_t    res
);

	phase_t     phase_q, phase_d;
	logic [2:0] body_cnt_q, body_cnt_d;
	logic [7:0] xor_q, xor_d;
	logic [1:0] dig_cnt_q, dig_cnt_d;
	logic [7:0] recv_q, recv_d;
	logic       dig_bad_q, dig_bad_d;
	digit_t     dig;
	logic [7:0] add;

	assign dig = char_value(msg_byte);
	assign add = (dig_cnt_q == 2'd0) ? {dig.val[3:0], 4'b0000} : {2'b00, dig.val};

	// Apply one byte to the parse state.
	always_comb begin
		phase_d    = phase_q;
		body_cnt_d = body_cnt_q;
		xor_d      = xor_q;
		dig_cnt_d  = dig_cnt_q;
		recv_d     = recv_q;
		dig_bad_d  = dig_bad_q;
		case (phase_q)
			PH_BODY: begin
				if (msg_byte == STAR_CHAR) begin
					phase_d = PH_SUM;
				end else begin
					if (body_cnt_q != 3'd0)
						xor_d = xor_q ^ msg_byte;
					if (body_cnt_q < MIN_BODY)
						body_cnt_d = body_cnt_q + 3'd1;
				end
			end
			PH_SUM: begin
				if (msg_byte == STAR_CHAR) begin
					phase_d = PH_TAIL;
				end else begin
					if (dig_cnt_q < DIGITS_NEEDED) begin
						if (!dig.ok)
							dig_bad_d = 1'b1;
						else
							recv_d = recv_q + add;
					end
					if (dig_cnt_q < DIGIT_SAT)
						dig_cnt_d = dig_cnt_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Verdict from the state after this byte.
	always_comb begin
		if (body_cnt_d < MIN_BODY)
			res.status = ST_SHORT;
		else if (phase_d == PH_BODY || dig_cnt_d == 2'd0)
			res.status = ST_NO_CSUM;
		else if (dig_cnt_d != DIGITS_NEEDED)
			res.status = ST_BAD_LEN;
		else if (dig_bad_d)
			res.status = ST_BAD_DIG;
		else if (recv_d == xor_d)
			res.status = ST_MATCH;
		else
			res.status = ST_MISMATCH;
		res.checksum_ok  = (res.status == ST_MATCH) || (res.status == ST_NO_CSUM);
		res.computed_sum = xor_d;
	end

	// State registers; the last byte returns the parser to its start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_BODY;
			body_cnt_q <= 3'd0;
			xor_q      <= 8'd0;
			dig_cnt_q  <= 2'd0;
			recv_q     <= 8'd0;
			dig_bad_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q    <= PH_BODY;
				body_cnt_q <= 3'd0;
				xor_q      <= 8'd0;
				dig_cnt_q  <= 2'd0;
				recv_q     <= 8'd0;
				dig_bad_q  <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				body_cnt_q <= body_cnt_d;
				xor_q      <= xor_d;
				dig_cnt_q  <= dig_cnt_d;
				recv_q     <= recv_d;
				dig_bad_q  <= dig_bad_d;
			end
		end
	end

endmodule

### rtl/core/nsc_out_stage.sv
// Output register holding one verdict until the sink takes it.
// Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_out_stage import nsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    space,
	output logic    tvalid,
	input  logic    tready,
	output result_t data
);

	logic    valid_q;
	result_t data_q;

	// Room for a new item when empty or when the held item leaves now.
	assign space  = !valid_q || tready;
	assign tvalid = valid_q;
	assign data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space)
			data_q <= res;
	end

endmodule
